FILE: design/swtm_pkg.sv
// shared constants and types of the sliding-window trimmed mean unit
// no dependencies; used by the cell, the top level and the checker
package swtm_pkg;

  localparam int MAX_WINDOW_DEFAULT  = 64;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  localparam int WSIZE_W = 7;
  localparam int TRIM_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT  = 2'd1;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd64;
  localparam logic [TRIM_W-1:0]  TRIM_RESET  = 5'd1;

  // one operation per cycle on the row of sorted cells
  typedef struct packed {
    logic del;
    logic ins;
  } cell_op_t;

endpackage

FILE: design/swtm_cell.sv
// one slot of the sorted window: value plus age, shifts with its neighbors
// depends on swtm_pkg
module swtm_cell #(
  parameter int IDX = 0,
  parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEFAULT,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic                   clk,
  input  swtm_pkg::cell_op_t     op,
  input  logic [SAMPLE_BITS-1:0] v_old,
  input  logic [SAMPLE_BITS-1:0] s,
  input  logic [CW-1:0]          n,
  input  logic [IW-1:0]          age_last,
  input  logic [SAMPLE_BITS-1:0] left_val,
  input  logic [IW-1:0]          left_age,
  input  logic                   left_le,
  input  logic [SAMPLE_BITS-1:0] right_val,
  input  logic [IW-1:0]          right_age,
  output logic [SAMPLE_BITS-1:0] val,
  output logic [IW-1:0]          age,
  output logic                   le,
  output logic                   oldest
);

  logic occ;
  logic at_or_right_of_del;

  assign occ = CW'(IDX) < n;
  assign le = occ && (val <= s);
  assign oldest = occ && (age == age_last);
  // oldest equal value sits leftmost, so >= finds the deleted slot and all right of it
  assign at_or_right_of_del = occ && (val >= v_old);

  always_ff @(posedge clk) begin
    if (op.del) begin
      if (at_or_right_of_del) begin
        val <= right_val;
        age <= right_age;
      end
    end else if (op.ins) begin
      if (le) begin
        age <= age + IW'(1);
      end else if (left_le) begin
        val <= s;
        age <= '0;
      end else begin
        val <= left_val;
        age <= left_age + IW'(1);
      end
    end
  end

endmodule

FILE: design/sliding_window_trimmed_mean_unit.sv
// top level of the sliding-window trimmed mean unit: control, sum and divider
// depends on swtm_pkg and swtm_cell
//
// Alpha-trimmed mean over the last window_size samples, capped at MAX_WINDOW.
// The window is held sorted in a row of cells, each with its sample and its
// age, so the oldest sample is found by age and no separate ring is kept. One
// transaction at a time: a full window steps through find, delete and insert,
// then adds up the dropped ends, then runs the restoring divider, loads the
// output register and goes back to idle. A window that is not yet full skips
// find and delete, and a window that is not yet full or a bad configuration
// skips the sum and divide. A stalled result holds the unit in its done state
// until the output register frees up. The output register lets the next
// sample be taken while a result still waits downstream.
module sliding_window_trimmed_mean_unit #(
  parameter int MAX_WINDOW  = swtm_pkg::MAX_WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [swtm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swtm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [SAMPLE_BITS-1:0]           trimmed_mean,
  output logic                             window_full,
  output logic                             bad_config
);

  localparam int IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SAMPLE_BITS + CW;
  localparam int EW   = (CW > swtm_pkg::WSIZE_W) ? CW : swtm_pkg::WSIZE_W;
  localparam int BW   = CW + swtm_pkg::TRIM_W + 1;
  localparam int DCW  = $clog2(SUMW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // configuration
  logic [swtm_pkg::WSIZE_W-1:0] window_size;
  logic [swtm_pkg::TRIM_W-1:0]  trim_count;

  // control and datapath registers
  logic [2:0]             state;
  logic [CW-1:0]          fill;
  logic [SUMW-1:0]        window_sum;
  logic                   was_full;
  logic [SAMPLE_BITS-1:0] s_reg;
  logic [SAMPLE_BITS-1:0] v_old;
  logic [swtm_pkg::TRIM_W-1:0] cnt;
  logic [SUMW-1:0]        acc;
  logic [SUMW-1:0]        dividend;
  logic [CW-1:0]          rem;
  logic [DCW-1:0]         div_cnt;
  logic [SAMPLE_BITS-1:0] res_mean;
  logic                   res_full;
  logic                   res_bad;

  // derived
  logic [EW-1:0]          ws_ext;
  logic [CW-1:0]          m;
  logic                   bad;
  logic [CW-1:0]          divisor;
  logic [CW-1:0]          fill_next;
  logic                   full_next;
  logic [CW:0]            trial;
  logic [CW-1:0]          hi_pos;
  logic                   in_take;
  logic                   out_take;
  logic                   out_load;

  // cell row
  swtm_pkg::cell_op_t     op;
  logic [CW-1:0]          n_cells;
  logic [IW-1:0]          age_last;
  logic [SAMPLE_BITS-1:0] cv [MAX_WINDOW];
  logic [IW-1:0]          ca [MAX_WINDOW];
  logic                   cle [MAX_WINDOW];
  logic                   cold [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] old_val;

  assign ws_ext  = EW'(window_size);
  assign m       = (ws_ext > EW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(ws_ext);
  assign bad     = BW'({trim_count, 1'b0}) >= BW'(m);
  assign divisor = CW'(BW'(m) - BW'({trim_count, 1'b0}));
  assign fill_next = was_full ? fill : fill + CW'(1);
  assign full_next = fill_next >= m;
  assign trial   = {rem, dividend[SUMW-1]};
  assign hi_pos  = m - CW'(1) - CW'(cnt);

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  // the output register frees up when its transaction completes
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign op.del   = (state == S_DEL);
  assign op.ins   = (state == S_INS);
  // during insert a full window has one slot fewer after the delete
  assign n_cells  = (state == S_INS && was_full) ? fill - CW'(1) : fill;
  assign age_last = IW'(m - CW'(1));

  // the one-hot oldest flag picks the value to delete
  always_comb begin
    old_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      old_val = old_val | (cv[i] & {SAMPLE_BITS{cold[i]}});
    end
  end

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lv;
    logic [IW-1:0]          la;
    logic                   lle;
    logic [SAMPLE_BITS-1:0] rv;
    logic [IW-1:0]          ra;

    if (g == 0) begin : g_first
      assign lv  = '0;
      assign la  = '0;
      assign lle = 1'b1;
    end else begin : g_mid
      assign lv  = cv[g-1];
      assign la  = ca[g-1];
      assign lle = cle[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_last
      assign rv = '0;
      assign ra = '0;
    end else begin : g_inner
      assign rv = cv[g+1];
      assign ra = ca[g+1];
    end

    swtm_cell #(
      .IDX(g),
      .SAMPLE_BITS(SAMPLE_BITS),
      .IW(IW),
      .CW(CW)
    ) u_cell (
      .clk(clk),
      .op(op),
      .v_old(v_old),
      .s(s_reg),
      .n(n_cells),
      .age_last(age_last),
      .left_val(lv),
      .left_age(la),
      .left_le(lle),
      .right_val(rv),
      .right_age(ra),
      .val(cv[g]),
      .age(ca[g]),
      .le(cle[g]),
      .oldest(cold[g])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_size <= swtm_pkg::WSIZE_RESET;
      trim_count  <= swtm_pkg::TRIM_RESET;
      fill        <= '0;
      window_sum  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == swtm_pkg::REG_WINDOW_SIZE) begin
          // a resize empties the window
          window_size <= cfg_data[swtm_pkg::WSIZE_W-1:0];
          fill        <= '0;
          window_sum  <= '0;
        end else if (cfg_index == swtm_pkg::REG_TRIM_COUNT) begin
          trim_count <= cfg_data[swtm_pkg::TRIM_W-1:0];
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_take) begin
            was_full <= (fill >= m);
            if (m == '0) begin
              // empty window: always full, always bad
              res_mean <= '0;
              res_full <= 1'b1;
              res_bad  <= 1'b1;
              state    <= S_DONE;
            end else if (fill >= m) begin
              state <= S_FIND;
            end else begin
              state <= S_INS;
            end
          end
        end
        S_FIND: begin
          v_old <= old_val;
          state <= S_DEL;
        end
        S_DEL: begin
          state <= S_INS;
        end
        S_INS: begin
          fill <= fill_next;
          if (was_full) begin
            window_sum <= window_sum - SUMW'(v_old) + SUMW'(s_reg);
          end else begin
            window_sum <= window_sum + SUMW'(s_reg);
          end
          res_full <= full_next;
          res_bad  <= bad;
          res_mean <= '0;
          cnt      <= '0;
          acc      <= '0;
          if (full_next && !bad) begin
            state <= S_SUM;
          end else begin
            state <= S_DONE;
          end
        end
        S_SUM: begin
          // drop the trim_count smallest and largest, one pair a cycle
          if (cnt == trim_count) begin
            dividend <= window_sum - acc;
            rem      <= '0;
            div_cnt  <= '0;
            state    <= S_DIV;
          end else begin
            acc <= acc + SUMW'(cv[IW'(cnt)]) + SUMW'(cv[hi_pos[IW-1:0]]);
            cnt <= cnt + swtm_pkg::TRIM_W'(1);
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (trial >= (CW+1)'(divisor)) begin
            rem      <= CW'(trial - (CW+1)'(divisor));
            dividend <= {dividend[SUMW-2:0], 1'b1};
          end else begin
            rem      <= trial[CW-1:0];
            dividend <= {dividend[SUMW-2:0], 1'b0};
          end
          if (div_cnt == DCW'(SUMW - 1)) begin
            state <= S_DONE;
          end
          div_cnt <= div_cnt + DCW'(1);
          res_mean <= SAMPLE_BITS'({dividend[SUMW-2:0], trial >= (CW+1)'(divisor)});
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s_reg <= sample;
    end
    if (out_load) begin
      trimmed_mean <= res_mean;
      window_full  <= res_full;
      bad_config   <= res_bad;
    end
  end

endmodule

FILE: design/swtm_checker.sv
// port-level checks of the sliding-window trimmed mean unit, bound to the top
// depends on swtm_pkg and sliding_window_trimmed_mean_unit
module swtm_checker #(
  parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEFAULT
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [SAMPLE_BITS-1:0]           trimmed_mean,
  input logic                             window_full,
  input logic                             bad_config
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(trimmed_mean))
    else $error("result changed while stalled");

  // an unusable configuration gives a zero mean
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_config |-> trimmed_mean == '0)
    else $error("nonzero mean with bad configuration");

  // a window that is not full gives a zero mean
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_full |-> trimmed_mean == '0)
    else $error("nonzero mean before window full");

  // no result straight out of reset
  a_no_early: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

endmodule

bind sliding_window_trimmed_mean_unit swtm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);

FILE: verif/testbench.sv
// self-checking testbench of sliding_window_trimmed_mean_unit
// depends on swtm_pkg and the unit; drives samples and config, predicts each result
`timescale 1ns / 100ps

module testbench;

  localparam int MAXW = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [swtm_pkg::CFG_IDX_W-1:0] cfg_index = swtm_pkg::REG_WINDOW_SIZE;
  logic [swtm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] trimmed_mean;
  logic window_full;
  logic bad_config;

  typedef struct packed {
    logic [15:0] mean;
    logic full;
    logic bad;
  } filt_result_t;

  // mirror of the filter state
  logic [15:0] ring_q [MAXW];
  logic [15:0] sorted_q [$];
  int unsigned oldest_pos, held;
  int unsigned win_size, trim;

  logic [15:0] pending_samples [$];
  filt_result_t expected_results [$];
  bit failed = 1'b0;
  int unsigned drive_gap = 0;
  int unsigned sink_gap = 0;

  sliding_window_trimmed_mean_unit dut (.*);

  always #5 clk = ~clk;

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // advance the window by one sample and return the trimmed mean result
  function automatic filt_result_t trimmed_mean_of(logic [15:0] s);
    filt_result_t r;
    int unsigned m, pos, i;
    logic [15:0] old;
    longint unsigned mid;
    m = (win_size > MAXW) ? MAXW : win_size;
    r.bad = (2 * trim) >= m;
    if (m > 0) begin
      if (held < m) begin
        pos = (oldest_pos + held) % m;
        held++;
      end else begin
        pos = oldest_pos % m;
        old = ring_q[pos];
        for (i = 0; i < sorted_q.size(); i++)
          if (sorted_q[i] == old) begin
            sorted_q.delete(i);
            break;
          end
        oldest_pos = (pos + 1) % m;
      end
      ring_q[pos] = s;
      i = 0;
      while (i < sorted_q.size() && sorted_q[i] <= s) i++;
      sorted_q.insert(i, s);
    end
    r.full = held >= m;
    r.mean = '0;
    if (r.full && !r.bad) begin
      mid = 0;
      for (i = trim; i < m - trim; i++) mid += sorted_q[i];
      r.mean = 16'(mid / (m - 2 * trim));
    end
    return r;
  endfunction

  // driver: one sample transaction at a time from the pending queue
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), trimmed_mean_of(sample));
        drive_gap <= rand_gap();
      end
      if (!(in_valid && in_stall)) begin
        if (drive_gap > 0 && !(in_valid && !in_stall)) begin
          drive_gap <= drive_gap - 1;
          in_valid <= 1'b0;
        end else if ((in_valid && !in_stall) ? (pending_samples.size() > 0 &&
                     rand_gap() == 0) : pending_samples.size() > 0) begin
          // back-to-back or resume after a gap
          in_valid <= 1'b1;
          sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    filt_result_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result mean=%0d full=%0d bad=%0d", $time,
                   trimmed_mean, window_full, bad_config);
          failed = 1'b1;
        end else begin
          e = expected_results.pop_front();
          if (e.mean !== trimmed_mean || e.full !== window_full ||
              e.bad !== bad_config) begin
            $display("%0t expected mean=%0d full=%0d bad=%0d actual mean=%0d full=%0d bad=%0d",
                     $time, e.mean, e.full, e.bad, trimmed_mean, window_full,
                     bad_config);
            failed = 1'b1;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        sink_gap <= rand_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [swtm_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= swtm_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == swtm_pkg::REG_WINDOW_SIZE) begin
      win_size = value & 7'h7f;
      oldest_pos = 0;
      held = 0;
      sorted_q.delete();
    end else if (idx == swtm_pkg::REG_TRIM_COUNT) begin
      trim = value & 5'h1f;
    end
  endtask

  // samples are fully random half the time, else extremes or small values, so duplicates are common
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(int unsigned ws, int unsigned tc, int unsigned n);
    wait_drained();
    write_reg(swtm_pkg::REG_WINDOW_SIZE, ws);
    write_reg(swtm_pkg::REG_TRIM_COUNT, tc);
    repeat (n) pending_samples.insert(pending_samples.size(), rand_sample());
  endtask

  initial begin
    int unsigned ws, tc;
    win_size = swtm_pkg::WSIZE_RESET;
    trim = swtm_pkg::TRIM_RESET;
    oldest_pos = 0;
    held = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: reset config, extremes, duplicates
    pending_samples = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'h5555,
                        16'haaaa, 16'h0000, 16'hffff, 16'h0003, 16'h0003, 16'h0003};
    // window of three, trim of one; then zero, one and two windows
    run_phase(3, 1, 6);
    run_phase(0, 0, 3);
    run_phase(1, 0, 4);
    run_phase(2, 0, 4);
    run_phase(2, 1, 3);
    // oversized window saturates
    run_phase(127, 31, 70);
    // trim change mid-stream keeps the window
    run_phase(5, 0, 8);
    wait_drained();
    write_reg(swtm_pkg::REG_TRIM_COUNT, 2);
    repeat (6) pending_samples.insert(pending_samples.size(), rand_sample());
    // randomized phases, mostly small windows
    for (int p = 0; p < 40; p++) begin
      ws = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 20);
      tc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(0, ws / 2);
      run_phase(ws, tc, 25);
    end
    run_phase(64, 31, 80);
    run_phase(64, 0, 80);
    wait_drained();
    if (!failed) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
